/* design/gb5_pkg.sv */
`default_nettype none
package gb5_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 2048;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned FW_W          = 12;
  localparam int unsigned FH_W          = 13;
  localparam int unsigned ORW_W         = 12;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned CFG_DW        = 13;
  localparam int unsigned VSUM_W        = 12;
  localparam int unsigned TERM_W        = 16;
  localparam int unsigned TAPS          = 5;

  localparam logic [FW_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  // 1-4-6-4-1 binomial taps; the 5x5 kernel is their outer product
  localparam int unsigned KERNEL_TAP [TAPS] = '{1, 4, 6, 4, 1};

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [VSUM_W-1:0] r;
    logic [VSUM_W-1:0] g;
    logic [VSUM_W-1:0] b;
  } vsum_t;

  typedef struct packed {
    logic [TERM_W-1:0] r;
    logic [TERM_W-1:0] g;
    logic [TERM_W-1:0] b;
  } term_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic mask;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* design/gb5_if.sv */
`default_nettype none
interface gb5_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface gb5_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

/* design/gaussian_blur_5x5_rgb.sv */
// 5x5 binomial blur over an RGB pixel stream in raster order.
// pix_i: one pixel per transfer (command = pixel) or a flush step (command = flush).
// A flush while pixels of the frame are still due is dropped. After the last pixel
// of the frame, 2*width+2 further transfers (any command) push out the tail.
// res_o: one blurred pixel per transfer, lagging its centre by two rows and two
// pixels; frame_end marks the last pixel, after which a new frame starts.
// cfg: write frame_width (index 0) or frame_height (index 1) only while idle; each
// write restarts the frame. Reset gives 640x480 and an empty window.
// A result passes stage 1, stage 2 and the output register on its way to res_o.
// Throughput: one pixel per cycle while res_o takes results, set by the single line
// store that is read and written once per pixel; a column cell chain forms the 5x5 window.
// When res_o stalls, a full output register holds and pix_i.ready drops the same
// cycle; the whole pipe freezes and resumes without loss.
`default_nettype none
module gaussian_blur_5x5_rgb #(
  parameter int unsigned MAX_WIDTH = gb5_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  gb5_pix_if.sink                         pix_i,
  gb5_res_if.source                       res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [gb5_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW   = WW + 1;
  localparam int unsigned CNTW = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned FH_W = gb5_pkg::FH_W;
  localparam int unsigned RW   = gb5_pkg::ORW_W;
  localparam int unsigned TAPS = gb5_pkg::TAPS;

  logic [gb5_pkg::FW_W-1:0] fw_q;
  logic [FH_W-1:0]          fh_q;
  logic [WW-1:0]            w_eff;
  logic [FH_W-1:0]          h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= gb5_pkg::WIDTH_RST;
      fh_q <= gb5_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (gb5_pkg::cfg_reg_e'(cfg_idx_i))
        gb5_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data_i[gb5_pkg::FW_W-1:0];
        gb5_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_q);
    end
    if (fh_q == '0) begin
      h_eff = FH_W'(1);
    end else if (32'(fh_q) > 32'(gb5_pkg::HEIGHT_LIMIT)) begin
      h_eff = FH_W'(gb5_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = fh_q;
    end
  end

  // pipeline enable
  logic out_valid_q;
  logic en;
  assign en = !out_valid_q || res_o.ready;
  assign pix_i.ready = en;

  logic acc;
  assign acc = pix_i.valid && en;

  // front: positions
  logic [CW-1:0]   in_col_q, in_col_d;
  logic [FH_W-1:0] in_row_q, in_row_d;
  logic [CW-1:0]   out_col_q, out_col_d;
  logic [RW-1:0]   out_row_q, out_row_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  logic            in_frame, proc, emit, last;
  logic [CNTW-1:0] prime;
  logic [PW-1:0]   icol_p1, ocol_p, w_p;
  logic [3:0]      vmask;
  logic [TAPS-1:0] cmask;
  gb5_pkg::rgb_t   pix_new;

  logic            s1_proc_q;
  logic [CW-1:0]   s1_col_q;

  always_comb begin
    in_frame = in_row_q < h_eff;
    proc     = acc && !(in_frame && (gb5_pkg::cmd_e'(pix_i.command) == gb5_pkg::CMD_FLUSH));
    pix_new  = '0;
    if (in_frame) begin
      pix_new = '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
    end
    prime   = (CNTW'(w_eff) << 1) + CNTW'(2);
    emit    = proc && (cnt_q >= prime);
    w_p     = PW'(w_eff);
    icol_p1 = PW'(in_col_q) + PW'(1);
    ocol_p  = PW'(out_col_q);
    last    = ((FH_W'(out_row_q) + FH_W'(1)) >= h_eff) && ((ocol_p + PW'(1)) >= w_p);

    vmask[0] = in_row_q >= FH_W'(4);
    vmask[1] = in_row_q >= FH_W'(3);
    vmask[2] = in_row_q >= FH_W'(2);
    vmask[3] = in_row_q >= FH_W'(1);

    cmask[0] = ocol_p >= PW'(2);
    cmask[1] = ocol_p >= PW'(1);
    cmask[2] = 1'b1;
    cmask[3] = (ocol_p + PW'(1)) < w_p;
    cmask[4] = (ocol_p + PW'(2)) < w_p;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    cnt_d     = cnt_q;
    if (cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      cnt_d     = '0;
    end else if (proc) begin
      if (icol_p1 >= w_p) begin
        in_col_d = '0;
        in_row_d = in_row_q + FH_W'(1);
      end else begin
        in_col_d = icol_p1[CW-1:0];
      end
      if (!emit) begin
        cnt_d = cnt_q + CNTW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
          cnt_d     = '0;
        end else if ((ocol_p + PW'(1)) >= w_p) begin
          out_col_d = '0;
          out_row_d = out_row_q + RW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      cnt_q     <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      cnt_q     <= cnt_d;
    end
  end

  // stage 1: line store read returns, new column formed
  logic            s1_emit_q, s1_last_q, byp_q;
  logic [3:0]      s1_vmask_q;
  logic [TAPS-1:0] s1_cmask_q;
  gb5_pkg::rgb_t   s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_proc_q <= 1'b0;
      s1_emit_q <= 1'b0;
      s1_last_q <= 1'b0;
      byp_q     <= 1'b0;
    end else if (en) begin
      s1_proc_q <= proc;
      s1_emit_q <= emit;
      s1_last_q <= emit && last;
      byp_q     <= proc && s1_proc_q && (s1_col_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_col_q   <= in_col_q;
      s1_pix_q   <= pix_new;
      s1_vmask_q <= vmask;
      s1_cmask_q <= cmask;
    end
  end

  gb5_pkg::rgb_t [3:0] ram_rd, ram_wd, raw, wlast_q;
  logic                ram_we;

  assign ram_we = en && s1_proc_q;

  gb5_ram #(
    .WIDTH ($bits(gb5_pkg::rgb_t) * 4),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wd),
    .re_i    (en),
    .raddr_i (in_col_q),
    .rdata_o (ram_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wlast_q <= ram_wd;
    end
  end

  gb5_pkg::rgb_t [TAPS-1:0] colpix;
  gb5_pkg::vsum_t           newcol;

  always_comb begin
    raw    = byp_q ? wlast_q : ram_rd;
    ram_wd = {s1_pix_q, raw[3], raw[2], raw[1]};
    for (int k = 0; k < 4; k++) begin
      colpix[k] = s1_vmask_q[k] ? raw[k] : '0;
    end
    colpix[4] = s1_pix_q;
    newcol = '0;
    for (int k = 0; k < TAPS; k++) begin
      newcol.r = newcol.r + gb5_pkg::VSUM_W'(gb5_pkg::KERNEL_TAP[k]) *
                 gb5_pkg::VSUM_W'(colpix[k].r);
      newcol.g = newcol.g + gb5_pkg::VSUM_W'(gb5_pkg::KERNEL_TAP[k]) *
                 gb5_pkg::VSUM_W'(colpix[k].g);
      newcol.b = newcol.b + gb5_pkg::VSUM_W'(gb5_pkg::KERNEL_TAP[k]) *
                 gb5_pkg::VSUM_W'(colpix[k].b);
    end
  end

  // stage 2: column cells hold the window, result formed into output register
  logic            s2_emit_q, s2_last_q;
  logic [TAPS-1:0] s2_cmask_q;
  logic            clr;

  assign clr = cfg_we_i || (en && s2_emit_q && s2_last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_emit_q <= 1'b0;
      s2_last_q <= 1'b0;
    end else if (en) begin
      s2_emit_q <= s1_proc_q && s1_emit_q;
      s2_last_q <= s1_proc_q && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cmask_q <= s1_cmask_q;
    end
  end

  gb5_pkg::vsum_t     cell_q  [TAPS];
  gb5_pkg::term_t     term    [TAPS];
  gb5_pkg::cell_ctl_t cell_ctl[TAPS];

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    gb5_pkg::vsum_t din;
    if (j == TAPS - 1) begin : g_head
      assign din = newcol;
      assign cell_ctl[j] = '{shift: ram_we, clear: clr && !ram_we, mask: s2_cmask_q[j]};
    end else begin : g_body
      assign din = cell_q[j+1];
      assign cell_ctl[j] = '{shift: ram_we, clear: clr, mask: s2_cmask_q[j]};
    end
    gb5_cell #(
      .WEIGHT (gb5_pkg::KERNEL_TAP[j])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (cell_ctl[j]),
      .vsum_i (din),
      .vsum_o (cell_q[j]),
      .term_o (term[j])
    );
  end

  gb5_pkg::term_t total;

  always_comb begin
    total = '0;
    for (int j = 0; j < TAPS; j++) begin
      total.r = total.r + term[j].r;
      total.g = total.g + term[j].g;
      total.b = total.b + term[j].b;
    end
  end

  logic          out_last_q;
  gb5_pkg::rgb_t out_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pix_q  <= '{r: total.r[15:8], g: total.g[15:8], b: total.b[15:8]};
      out_last_q <= s2_last_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.red_out   = out_pix_q.r;
  assign res_o.green_out = out_pix_q.g;
  assign res_o.blue_out  = out_pix_q.b;
  assign res_o.frame_end = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= prime)
    else $error("fill count past window depth");

  a_out_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(out_col_q) < w_p)
    else $error("output column beyond frame width");

  a_byp_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> s1_proc_q)
    else $error("bypass without item in stage 1");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last && !cfg_we_i) |=> (in_row_q == '0 && cnt_q == '0 && out_row_q == '0))
    else $error("frame did not restart after last pixel");

endmodule
`default_nettype wire

/* design/gb5_ram.sv */
`default_nettype none
module gb5_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read-first: a read and write to one address returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

/* design/gb5_cell.sv */
`default_nettype none
module gb5_cell #(
  parameter int unsigned WEIGHT = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gb5_pkg::cell_ctl_t ctl_i,
  input  wire gb5_pkg::vsum_t    vsum_i,
  output gb5_pkg::vsum_t         vsum_o,
  output gb5_pkg::term_t         term_o
);

  gb5_pkg::vsum_t vsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsum_q <= '0;
    end else if (ctl_i.shift) begin
      vsum_q <= ctl_i.clear ? '0 : vsum_i;
    end else if (ctl_i.clear) begin
      vsum_q <= '0;
    end
  end

  assign vsum_o = vsum_q;

  always_comb begin
    term_o = '0;
    if (ctl_i.mask) begin
      term_o.r = gb5_pkg::TERM_W'(WEIGHT) * gb5_pkg::TERM_W'(vsum_q.r);
      term_o.g = gb5_pkg::TERM_W'(WEIGHT) * gb5_pkg::TERM_W'(vsum_q.g);
      term_o.b = gb5_pkg::TERM_W'(WEIGHT) * gb5_pkg::TERM_W'(vsum_q.b);
    end
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;

  typedef struct {
    gb5_pkg::cmd_e cmd;
    gb5_pkg::rgb_t px;
  } pix_item_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fe;
  } blur_px_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [gb5_pkg::CFG_DW-1:0] cfg_data;

  gb5_pix_if pix ();
  gb5_res_if res ();

  gaussian_blur_5x5_rgb DUT (
    .clk_i(clk),
    .rst_ni(rst_n),
    .pix_i(pix),
    .res_o(res),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  pix_item_t pixel_q[$];
  blur_px_t  blur_q[$];
  int push_cnt, acc_cnt, res_cnt, frame_cnt, err_cnt;
  bit no_idle, hold_req, hold_done;
  int hold_left;

  // shadow of the blur engine
  logic [gb5_pkg::FW_W-1:0] m_width;
  logic [gb5_pkg::FH_W-1:0] m_height;
  logic [23:0] m_lines [4*gb5_pkg::DEF_MAX_WIDTH];
  logic [23:0] m_win [5][5];
  int unsigned m_in_col, m_in_row, m_out_col, m_out_row;

  function automatic void restart_frame();
    for (int k = 0; k < 5; k++)
      for (int m = 0; m < 5; m++) m_win[k][m] = '0;
    m_in_col = 0;
    m_in_row = 0;
    m_out_col = 0;
    m_out_row = 0;
  endfunction

  function automatic bit blur_step(input pix_item_t it, output blur_px_t o);
    int unsigned w, h, col, row, lin, wt;
    int y, x;
    logic [23:0] pxl, v;
    int unsigned sr, sg, sb;
    bit last;
    w = (m_width == 0) ? 1 :
        (m_width > gb5_pkg::DEF_MAX_WIDTH) ? gb5_pkg::DEF_MAX_WIDTH : m_width;
    h = (m_height == 0) ? 1 :
        (m_height > gb5_pkg::HEIGHT_LIMIT) ? gb5_pkg::HEIGHT_LIMIT : m_height;
    col = m_in_col;
    row = m_in_row;
    sr = 0;
    sg = 0;
    sb = 0;
    o = '{default: '0};
    if (row < h && it.cmd == gb5_pkg::CMD_FLUSH) return 0;
    pxl = (row < h) ? it.px : 24'h0;
    if (col >= gb5_pkg::DEF_MAX_WIDTH) col = gb5_pkg::DEF_MAX_WIDTH - 1;
    for (int k = 0; k < 5; k++)
      for (int m = 0; m < 4; m++) m_win[k][m] = m_win[k][m+1];
    for (int k = 0; k < 4; k++)
      m_win[k][4] = (row + k >= 4) ?
                    m_lines[((row + k) % 4) * gb5_pkg::DEF_MAX_WIDTH + col] : 24'h0;
    m_win[4][4] = pxl;
    m_lines[(row % 4) * gb5_pkg::DEF_MAX_WIDTH + col] = pxl;
    lin = row * w + col;
    if (col + 1 >= w) begin
      m_in_col = 0;
      m_in_row = row + 1;
    end else begin
      m_in_col = col + 1;
    end
    if (lin < 2 * w + 2) return 0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        y = int'(m_out_row) + i - 2;
        x = int'(m_out_col) + j - 2;
        if (y >= 0 && x >= 0 && y < int'(h) && x < int'(w)) begin
          v = m_win[i][j];
          wt = gb5_pkg::KERNEL_TAP[i] * gb5_pkg::KERNEL_TAP[j];
          sr += v[23:16] * wt;
          sg += v[15:8] * wt;
          sb += v[7:0] * wt;
        end
      end
    end
    last = (m_out_row + 1 >= h) && (m_out_col + 1 >= w);
    o.r = sr[15:8];
    o.g = sg[15:8];
    o.b = sb[15:8];
    o.fe = last;
    if (last) begin
      restart_frame();
    end else if (m_out_col + 1 >= w) begin
      m_out_col = 0;
      m_out_row = m_out_row + 1;
    end else begin
      m_out_col = m_out_col + 1;
    end
    return 1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // pixel driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
      pix.command <= gb5_pkg::CMD_PIXEL;
      pix.red_in <= '0;
      pix.green_in <= '0;
      pix.blue_in <= '0;
    end else if (!pix.valid || pix.ready) begin
      if (pixel_q.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
        pix.valid <= 1'b1;
        pix.command <= pixel_q[0].cmd;
        pix.red_in <= pixel_q[0].px.r;
        pix.green_in <= pixel_q[0].px.g;
        pix.blue_in <= pixel_q[0].px.b;
        pixel_q.pop_front();
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // result sink with one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res.ready <= 1'b0;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      res.ready <= no_idle || $urandom_range(99) >= 34;
    end
  end

  // predictor and checker
  always @(posedge clk) begin
    pix_item_t it;
    blur_px_t e;
    if (!rst_n) begin
      m_width = gb5_pkg::WIDTH_RST;
      m_height = gb5_pkg::HEIGHT_RST;
      restart_frame();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == gb5_pkg::REG_FRAME_WIDTH) m_width = cfg_data[gb5_pkg::FW_W-1:0];
        else m_height = cfg_data[gb5_pkg::FH_W-1:0];
        restart_frame();
      end
      if (pix.valid && pix.ready) begin
        acc_cnt++;
        it.cmd = gb5_pkg::cmd_e'(pix.command);
        it.px = {pix.red_in, pix.green_in, pix.blue_in};
        if (blur_step(it, e)) blur_q.insert(blur_q.size(), e);
      end
      if (res.valid && res.ready) begin
        res_cnt++;
        if (blur_q.size() == 0) begin
          err_cnt++;
          $display("%0t: exp none act r=%0d g=%0d b=%0d fe=%0d", $time,
                   res.red_out, res.green_out, res.blue_out, res.frame_end);
        end else begin
          e = blur_q.pop_front();
          if (res.frame_end) frame_cnt++;
          if ({res.red_out, res.green_out, res.blue_out, res.frame_end} !==
              {e.r, e.g, e.b, e.fe}) begin
            err_cnt++;
            $display("%0t: exp r=%0d g=%0d b=%0d fe=%0d act r=%0d g=%0d b=%0d fe=%0d",
                     $time, e.r, e.g, e.b, e.fe, res.red_out, res.green_out,
                     res.blue_out, res.frame_end);
          end
        end
      end
    end
  end

  task automatic queue_pixel(input gb5_pkg::cmd_e c, input gb5_pkg::rgb_t p);
    pix_item_t item;
    item = '{cmd: c, px: p};
    pixel_q.insert(pixel_q.size(), item);
    push_cnt++;
  endtask

  // fill: 0 random, 1 all ones, 2 all zeros
  task automatic add_frame(input int w, input int h, input int fill, input bit whole = 1);
    gb5_pkg::rgb_t p;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(19) == 0)
        queue_pixel(gb5_pkg::CMD_FLUSH, gb5_pkg::rgb_t'(24'($urandom)));
      p = gb5_pkg::rgb_t'(24'($urandom));
      if (fill == 1) p = '1;
      else if (fill == 2) p = '0;
      queue_pixel(gb5_pkg::CMD_PIXEL, p);
    end
    if (whole)
      for (int i = 0; i < 2 * w + 2; i++)
        queue_pixel(($urandom_range(3) == 0) ? gb5_pkg::CMD_PIXEL : gb5_pkg::CMD_FLUSH,
                    gb5_pkg::rgb_t'(24'($urandom)));
  endtask

  task automatic drain();
    while (acc_cnt != push_cnt || blur_q.size() != 0 || pix.valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input gb5_pkg::cfg_reg_e idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= gb5_pkg::CFG_DW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h);
    drain();
    write_reg(gb5_pkg::REG_FRAME_WIDTH, w);
    write_reg(gb5_pkg::REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    int w, h;
    cfg_we = 1'b0;
    cfg_idx = gb5_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    wait (rst_n === 1'b1);
    set_size(1, 1);
    add_frame(1, 1, 0);
    set_size(0, 0);
    add_frame(1, 1, 1);
    set_size(3, 2);
    add_frame(3, 2, 1);
    add_frame(3, 2, 2);
    set_size(5, 5);
    add_frame(5, 5, 0, 0);
    set_size(7, 6);
    add_frame(7, 6, 0);
    drain();
    no_idle = 1'b1;
    add_frame(7, 6, 0);
    drain();
    no_idle = 1'b0;
    hold_req = 1'b1;
    set_size(8, 8);
    add_frame(8, 8, 0);
    add_frame(8, 8, 0);
    drain();
    while (push_cnt < 600) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_size(w, h);
      repeat ($urandom_range(1, 2)) add_frame(w, h, ($urandom_range(9) == 0) ? 1 : 0);
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Ran %0d pixel transfers over %0d frames, sizes 1x1 up to 8x8 incl. zero size,",
             acc_cnt, frame_cnt);
    $display("with dropped flushes, a mid-frame restart, a long sink stall and %0d results.",
             res_cnt);
    if (err_cnt == 0 && blur_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
